[src/wsmh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsmh_pkg: shared definitions for the word stream multiplicative hash
// Constants, the queued item format and the queue status bundle.
// ----------------------------------------------------------------------------
package wsmh_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned IN_TDATA_W = 72;   // 67 payload bits padded to 9 bytes
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [WORD_W-1:0] HASH_MULT  = 32'hc6a4a793;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'hbc9f1d34;
  localparam int unsigned WORD_SHIFT = 16;
  localparam int unsigned TAIL_SHIFT = 24;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QADDR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // How the back end folds an item into the running hash.
  typedef enum logic [1:0] {
    MIX_NONE = 2'd0,
    MIX_WORD = 2'd1,
    MIX_TAIL = 2'd2
  } mix_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] len;
    logic              first;
    logic              last;
    mix_kind_t         mix;
  } item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] cnt;
  } q_status_t;

endpackage

[src/wsmh_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsmh_front: input acceptance and item classification
// Unpacks an input beat, decides how it is mixed and masks tail bytes.
// ----------------------------------------------------------------------------
module wsmh_front (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wsmh_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  wsmh_pkg::q_status_t               q_status,
  output logic                              q_push,
  output wsmh_pkg::item_t                   q_item
);

  logic [wsmh_pkg::WORD_W-1:0]  word;
  logic [wsmh_pkg::COUNT_W-1:0] byte_count;
  logic [wsmh_pkg::WORD_W-1:0]  len;

  assign word       = in_tdata[31:0];
  assign byte_count = in_tdata[34:32];
  assign len        = in_tdata[66:35];

  assign in_tready = !q_status.full;
  assign q_push    = in_tvalid && !q_status.full;

  always_comb begin
    q_item.first = in_tuser;
    q_item.last  = in_tlast;
    q_item.len   = len;
    q_item.word  = word;
    q_item.mix   = wsmh_pkg::MIX_WORD;
    // Short counts only matter on the last beat; elsewhere the full word is mixed.
    if (in_tlast) begin
      case (byte_count)
        3'd0: begin
          q_item.mix = wsmh_pkg::MIX_NONE;
        end
        3'd1: begin
          q_item.mix  = wsmh_pkg::MIX_TAIL;
          q_item.word = {24'd0, word[7:0]};
        end
        3'd2: begin
          q_item.mix  = wsmh_pkg::MIX_TAIL;
          q_item.word = {16'd0, word[15:0]};
        end
        3'd3: begin
          q_item.mix  = wsmh_pkg::MIX_TAIL;
          q_item.word = {8'd0, word[23:0]};
        end
        default: begin
          q_item.mix = wsmh_pkg::MIX_WORD;
        end
      endcase
    end
  end

endmodule

[src/wsmh_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsmh_queue: short item queue between front and back
// Register based FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module wsmh_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsmh_pkg::item_t     push_item,
  input  logic                pop,
  output wsmh_pkg::item_t     head_item,
  output wsmh_pkg::q_status_t status
);

  localparam logic [wsmh_pkg::QADDR_W-1:0] LAST_SLOT =
    wsmh_pkg::QADDR_W'(wsmh_pkg::QDEPTH - 1);
  localparam logic [wsmh_pkg::QCNT_W-1:0] DEPTH_CNT =
    wsmh_pkg::QCNT_W'(wsmh_pkg::QDEPTH);

  wsmh_pkg::item_t                mem_r [wsmh_pkg::QDEPTH];
  logic [wsmh_pkg::QADDR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [wsmh_pkg::QADDR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [wsmh_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign status.full  = (cnt_r == DEPTH_CNT);
  assign status.empty = (cnt_r == '0);
  assign status.cnt   = cnt_r;
  assign head_item    = mem_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/wsmh_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsmh_back: hash sequencer and result register
// Runs add, multiply and shift-xor on one shared multiplier, holds the
// seed register and the output beat.
// ----------------------------------------------------------------------------
module wsmh_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [wsmh_pkg::WORD_W-1:0]        cfg_data,
  input  wsmh_pkg::q_status_t                q_status,
  input  wsmh_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wsmh_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [wsmh_pkg::WORD_W-1:0]  seed_r, seed_nxt;
  logic [wsmh_pkg::WORD_W-1:0]  hash_r, hash_nxt;
  logic [wsmh_pkg::WORD_W-1:0]  prod_r, prod_nxt;
  logic [wsmh_pkg::WORD_W-1:0]  sum_r, sum_nxt;
  logic [wsmh_pkg::WORD_W-1:0]  word_r, word_nxt;
  logic                         pend_r, pend_nxt;
  logic                         tail_r, tail_nxt;
  logic                         last_r, last_nxt;
  logic                         skip_r, skip_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [wsmh_pkg::WORD_W-1:0]  out_data_r, out_data_nxt;

  logic [wsmh_pkg::WORD_W-1:0]  mix_hash;
  logic [wsmh_pkg::WORD_W-1:0]  hash_cur;
  logic [wsmh_pkg::WORD_W-1:0]  seeded;
  logic [wsmh_pkg::WORD_W-1:0]  mul_a;
  logic [wsmh_pkg::WORD_W-1:0]  mul_p;

  // The last product is folded lazily: the shift-xor happens when the
  // running hash is next read.
  assign mix_hash = tail_r ? (prod_r ^ (prod_r >> wsmh_pkg::TAIL_SHIFT))
                           : (prod_r ^ (prod_r >> wsmh_pkg::WORD_SHIFT));
  assign hash_cur = pend_r ? mix_hash : hash_r;
  assign seeded   = seed_r ^ prod_r;

  // One shared multiplier: the length on a first beat, the sum otherwise.
  assign mul_a = (state_r == ST_MUL) ? sum_r : q_item.len;
  assign mul_p = mul_a * wsmh_pkg::HASH_MULT;

  assign q_pop      = (state_r == ST_IDLE) && !q_status.empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = cfg_valid ? cfg_data : seed_r;
    hash_nxt      = hash_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    word_nxt      = word_r;
    pend_nxt      = pend_r;
    tail_nxt      = tail_r;
    last_nxt      = last_r;
    skip_nxt      = skip_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          hash_nxt = hash_cur;
          pend_nxt = 1'b0;
          word_nxt = q_item.word;
          last_nxt = q_item.last;
          skip_nxt = (q_item.mix == wsmh_pkg::MIX_NONE);
          if (q_item.first) begin
            prod_nxt  = mul_p;
            state_nxt = ST_SEED;
          end else begin
            tail_nxt = (q_item.mix == wsmh_pkg::MIX_TAIL);
            sum_nxt  = hash_cur + q_item.word;
            state_nxt = (q_item.mix == wsmh_pkg::MIX_NONE) ? ST_EMIT : ST_MUL;
          end
        end
      end
      ST_SEED: begin
        hash_nxt  = seeded;
        sum_nxt   = seeded + word_r;
        state_nxt = skip_r ? ST_EMIT : ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = mul_p;
        pend_nxt  = 1'b1;
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hash_cur;
          hash_nxt      = hash_cur;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The tail flag of a first beat is taken at pop time as well.
    if ((state_r == ST_IDLE) && !q_status.empty && q_item.first) begin
      tail_nxt = (q_item.mix == wsmh_pkg::MIX_TAIL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= wsmh_pkg::SEED_RESET;
      hash_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      hash_r      <= hash_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    word_r     <= word_nxt;
    tail_r     <= tail_nxt;
    last_r     <= last_nxt;
    skip_r     <= skip_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[src/word_stream_multiplicative_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_stream_multiplicative_hash: 32-bit multiplicative stream hash
// Hashes a message delivered as little-endian 32-bit words.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      tdata: data_word, byte_count, total_length; tuser: first;
//                      tlast: last
//  out_     master     tdata: hash_value, emitted once per message on the last beat
//  cfg_     slave      cfg_data: seed, always ready
//
// In the back end a full word is added, then multiplied on the shared 32x32
// multiplier; a first beat adds a step for the length product and a last beat
// adds a step to load the output register.
// Reset is synchronous and active low; the seed returns to 0xbc9f1d34.
// A two-entry queue lets input beats be taken while the back end is busy, and
// the output register lets the next message proceed while a result waits.
// ----------------------------------------------------------------------------
module word_stream_multiplicative_hash (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [31:0] data_word, [34:32] byte_count, [66:35] total_length,
  // [71:67] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wsmh_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: [0] first
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  // out_tdata: [31:0] hash_value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wsmh_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsmh_pkg::WORD_W-1:0]        cfg_data
);

  wsmh_pkg::q_status_t q_status;
  wsmh_pkg::item_t     push_item;
  wsmh_pkg::item_t     head_item;
  logic                q_push;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  wsmh_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  wsmh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .status    (q_status)
  );

  wsmh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_status.cnt <= wsmh_pkg::QCNT_W'(wsmh_pkg::QDEPTH))
    else $error("queue count exceeds depth");

  // The back end only pops a present entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // A push without a pop grows the queue by exactly one entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_status.cnt == $past(q_status.cnt) + 1'b1))
    else $error("queue count did not follow a push");

endmodule
